[rtl/core/pst_pkg.sv]
`timescale 1ns / 1ps
package pst_pkg;

  localparam int SET_BITS         = 10;
  localparam int WAYS             = 4;
  localparam int PAGE_OFFSET_BITS = 12;
  localparam int ADDRESS_BITS     = 48;
  localparam int COUNTER_BITS     = 32;

  localparam int NUM_STATES = 8;
  localparam int STATE_W    = 3;
  localparam int NUM_SETS   = 1 << SET_BITS;
  localparam int TAG_W      = ADDRESS_BITS - PAGE_OFFSET_BITS;
  localparam int ENTRY_W    = 1 + TAG_W + STATE_W;
  localparam int ROW_W      = WAYS * ENTRY_W;
  localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_DEPTH  = NUM_STATES * NUM_STATES;
  localparam int CNT_AW     = 6;
  localparam int CLR_BITS   = (SET_BITS > CNT_AW) ? SET_BITS : CNT_AW;
  localparam int CLR_DEPTH  = (NUM_SETS > CNT_DEPTH) ? NUM_SETS : CNT_DEPTH;
  localparam int PAGES_W    = 13;
  localparam int IN_W       = 64;
  localparam int OUT_W      = 88;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_GET  = 2'd1,
    OP_CNT  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // bit t of entry f set when move f -> t is legal
  localparam logic [7:0] LEGAL_TO [NUM_STATES] = '{
    8'hFF, 8'h8C, 8'hE0, 8'hE0, 8'hE0, 8'hC0, 8'h00, 8'h00
  };

  typedef struct packed {
    logic clr;
    logic accept;
    logic row_wr;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_set;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/page_state_transition_table_top.sv]
`timescale 1ns / 1ps
// channel | dir | beat
// s_axis  | in  | tuser[1:0] opcode; tdata page_address, target_state, count_from, count_to
// m_axis  | out | tdata status, hit, found_state, illegal, counter_value, page_total,
//         |     | illegal_count
// Get, counter read, unused opcode: the row and counter RAMs are read on acceptance, then
// the result is registered from the lookup state. Set: set-row read, then row write with
// counter read, then counter write. The next beat is taken once back in idle.
// After reset a clearing pass over max(2^SET_BITS, 64) addresses (1024 here) zeroes the
// row and counter RAMs; s_axis_tready stays low meanwhile.
// One item at a time; a result held by m_axis_tready low stalls the next item's finish.
module page_state_transition_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // page_address[47:0] target_state[50:48]
                                     // count_from[53:51] count_to[56:54]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata   // status[0] hit[1] found_state[4:2] illegal[5]
                                     // counter_value[37:6] page_total[50:38]
                                     // illegal_count[82:51]
);
  import pst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pst_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_op_i    (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

[rtl/core/pst_ram.sv]
`timescale 1ns / 1ps
module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/core/pst_ctrl.sv]
`timescale 1ns / 1ps
module pst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pst_pkg::sts_t sts_i,
  output pst_pkg::cmd_t cmd_o
);
  import pst_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts_i.op_set) begin
          cmd_o.row_wr = 1'b1;
          state_d      = ST_UPDATE;
        end else if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/pst_datapath.sv]
`timescale 1ns / 1ps
module pst_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pst_pkg::cmd_t              cmd_i,
  output pst_pkg::sts_t              sts_o,
  input  logic [1:0]                 in_op_i,
  input  logic [pst_pkg::IN_W-1:0]   in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pst_pkg::OUT_W-1:0]  out_data_o
);
  import pst_pkg::*;

  logic [CLR_BITS-1:0]     clr_q;
  op_e                     op_q;
  logic [TAG_W-1:0]        page_q;
  logic [STATE_W-1:0]      ns_q;
  logic [SET_BITS-1:0]     set_idx;
  logic [TAG_W-1:0]        in_page;
  logic [STATE_W-1:0]      in_cf, in_ct;

  logic [ROW_W-1:0]        row_rd, row_wd;
  logic                    row_we;
  logic [SET_BITS-1:0]     row_waddr, row_raddr;
  logic [COUNTER_BITS-1:0] cnt_rd, cnt_wd;
  logic                    cnt_we, cnt_re;
  logic [CNT_AW-1:0]       cnt_waddr, cnt_raddr, trans_idx;

  logic                    hit, free;
  logic [WAY_BITS-1:0]     hit_way, free_way, sel_way;
  logic [STATE_W-1:0]      prev_state, tr_from;
  logic                    legal, clr_row, clr_cnt, commit;
  logic [ENTRY_W-1:0]      ent;
  logic [63:0]             cnt_ext;

  logic [COUNTER_BITS-1:0] illegal_q, illegal_d;
  logic [PAGES_W-1:0]      pages_q, pages_d;
  logic                    out_valid_q;
  logic [OUT_W-1:0]        out_q;
  logic                    r_status, r_hit, r_illegal;
  logic [STATE_W-1:0]      r_found;
  logic [31:0]             r_cval;

  assign in_page = in_data_i[ADDRESS_BITS-1:PAGE_OFFSET_BITS];
  assign in_cf   = in_data_i[53:51];
  assign in_ct   = in_data_i[56:54];
  assign set_idx = page_q[SET_BITS-1:0];

  assign clr_row = cmd_i.clr && ((clr_q >> SET_BITS) == '0);
  assign clr_cnt = cmd_i.clr && ((clr_q >> CNT_AW) == '0);

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      ent = row_rd[w*ENTRY_W +: ENTRY_W];
      if (ent[ENTRY_W-1]) begin
        if (!hit && ent[STATE_W +: TAG_W] == page_q) begin
          hit     = 1'b1;
          hit_way = WAY_BITS'(w);
        end
      end else if (!free) begin
        free     = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
  end

  assign prev_state = row_rd[hit_way*ENTRY_W +: STATE_W];
  assign sel_way    = hit ? hit_way : free_way;
  assign tr_from    = hit ? prev_state : STATE_W'(0);
  assign trans_idx  = {tr_from, ns_q};
  assign legal      = LEGAL_TO[prev_state][ns_q];
  assign commit     = cmd_i.fin && (op_q == OP_SET) && (hit || free);

  always_comb begin
    row_wd = row_rd;
    row_wd[sel_way*ENTRY_W +: ENTRY_W] = {1'b1, page_q, ns_q};
    if (cmd_i.clr) begin
      row_wd = '0;
    end
  end

  assign row_we    = clr_row || (cmd_i.row_wr && (hit || free));
  assign row_waddr = cmd_i.clr ? clr_q[SET_BITS-1:0] : set_idx;
  assign row_raddr = in_page[SET_BITS-1:0];

  assign cnt_re    = cmd_i.accept || cmd_i.row_wr;
  assign cnt_raddr = cmd_i.accept ? {in_cf, in_ct} : trans_idx;
  assign cnt_we    = clr_cnt || commit;
  assign cnt_waddr = cmd_i.clr ? clr_q[CNT_AW-1:0] : trans_idx;
  assign cnt_wd    = cmd_i.clr ? '0 : ((cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1);
  assign cnt_ext   = 64'(cnt_rd);

  pst_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (row_we),
    .waddr_i(row_waddr),
    .wdata_i(row_wd),
    .re_i   (cmd_i.accept),
    .raddr_i(row_raddr),
    .rdata_o(row_rd)
  );

  pst_ram #(.WIDTH(COUNTER_BITS), .DEPTH(CNT_DEPTH)) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wd),
    .re_i   (cnt_re),
    .raddr_i(cnt_raddr),
    .rdata_o(cnt_rd)
  );

  always_comb begin
    illegal_d = illegal_q;
    pages_d   = pages_q;
    if (cmd_i.fin && op_q == OP_SET && hit && !legal && illegal_q != '1) begin
      illegal_d = illegal_q + 1'b1;
    end
    if (cmd_i.fin && op_q == OP_SET && !hit && free && pages_q != '1) begin
      pages_d = pages_q + 1'b1;
    end
  end

  assign r_status  = (op_q == OP_SET) && !hit && !free;
  assign r_hit     = ((op_q == OP_SET) || (op_q == OP_GET)) && hit;
  assign r_found   = r_hit ? prev_state : STATE_W'(0);
  assign r_illegal = (op_q == OP_SET) && hit && !legal;
  assign r_cval    = (op_q == OP_CNT) ? cnt_ext[31:0] : 32'd0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_e'(in_op_i);
      page_q <= in_page;
      ns_q   <= in_data_i[50:48];
    end
    if (cmd_i.fin) begin
      out_q <= {5'd0, 32'(64'(illegal_d)), pages_d, r_cval, r_illegal, r_found,
                r_hit, r_status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      illegal_q   <= '0;
      pages_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_q <= clr_q + 1'b1;
      end
      illegal_q <= illegal_d;
      pages_q   <= pages_d;
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last = (clr_q == CLR_BITS'(CLR_DEPTH - 1));
  assign sts_o.op_set   = (op_q == OP_SET);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  a_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr |-> !(cmd_i.accept || cmd_i.row_wr || cmd_i.fin))
    else $error("clear overlaps item work");
  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |=> out_valid_q)
    else $error("result not presented");
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_i.fin)
    else $error("result overwritten");
  a_ill_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.fin |=> illegal_q == $past(illegal_q))
    else $error("illegal count moved without result");

endmodule
